>>> rtl/taa_pkg.sv
// Package for the temperature averaging and alarm block.
// Holds field widths, reset values, register and level codes, and width helpers.
// No dependencies.
package taa_pkg;

    localparam int ADC_W          = 10;
    localparam int AVG_W          = 10;
    localparam int TEMP_W         = 13;
    localparam int LEVEL_W        = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;

    localparam int ADC_MAX        = 1023;
    localparam int DEFAULT_WINDOW = 10;

    // Temperature = floor((NUM_GAIN * sum + NUM_BIAS * W) / (TDIV_GAIN * W)) - TEMP_OFFSET.
    localparam int NUM_GAIN       = 625;
    localparam int NUM_BIAS       = 124;
    localparam int TDIV_GAIN      = 156;
    localparam int TEMP_OFFSET    = 329;

    localparam logic signed [TEMP_W-1:0] ALARM_RESET = 13'sd1920;
    localparam logic signed [TEMP_W-1:0] WARN_RESET  = 13'sd1440;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM = 2'd0,
        CFG_WARN  = 2'd1
    } cfg_index_t;

    typedef enum logic [LEVEL_W-1:0] {
        LEVEL_NORMAL = 2'd0,
        LEVEL_WARN   = 2'd1,
        LEVEL_ALARM  = 2'd2
    } level_t;

    function automatic int sum_width(input int w);
        return $clog2(ADC_MAX * w + 1);
    endfunction

    function automatic int num_max(input int w);
        return (NUM_GAIN * ADC_MAX + NUM_BIAS) * w;
    endfunction

    function automatic int num_width(input int w);
        return $clog2(num_max(w) + 1);
    endfunction

    function automatic int tdiv(input int w);
        return TDIV_GAIN * w;
    endfunction

    function automatic int rem_width(input int w);
        return $clog2(2 * tdiv(w));
    endfunction

endpackage

>>> rtl/temperature_average_alarm.sv
// A result passes through the window sum register, the scale stages and the output register in that order.
// Throughput: one sample per cycle; each stage of the window register, the three-stage
// reciprocal multiply pipeline and the output register advances whenever it is empty
// or the stage after it advances, so a stalled output backs up the chain stage by stage.
// Reset: the window reads as all zeros through per-entry fill flags, the sum is
// zero, alarm and warning thresholds return to 1920 and 1440; no clearing pass.
module temperature_average_alarm
    import taa_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ADC_W-1:0]         adc_sample,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] temperature,
    output logic [AVG_W-1:0]         average_raw,
    output logic [LEVEL_W-1:0]       level
);

    localparam int SUM_W = sum_width(WINDOW);
    localparam int REM_W = rem_width(WINDOW);
    localparam int TDIV  = tdiv(WINDOW);
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = -13'sd329;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 13'sd3770;

    logic                     win_valid;
    logic                     win_stall;
    logic [SUM_W-1:0]         win_sum;
    logic                     sc_valid;
    logic                     sc_stall;
    logic [REM_W-1:0]         sc_rem;
    logic signed [TEMP_W-1:0] sc_temp_base;
    logic [AVG_W-1:0]         sc_avg;

    logic signed [TEMP_W-1:0] alarm_reg;
    logic signed [TEMP_W-1:0] alarm_next;
    logic signed [TEMP_W-1:0] warn_reg;
    logic signed [TEMP_W-1:0] warn_next;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [TEMP_W-1:0] temperature_reg;
    logic [AVG_W-1:0]         average_raw_reg;
    level_t                   level_reg;
    logic                     out_adv;
    logic signed [TEMP_W-1:0] temp_calc;
    level_t                   level_calc;

    taa_window #(
        .WINDOW     (WINDOW)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .sum_valid  (win_valid),
        .sum_stall  (win_stall),
        .sum        (win_sum)
    );

    taa_scale #(
        .WINDOW     (WINDOW)
    ) u_scale (
        .clk        (clk),
        .rst_n      (rst_n),
        .sum_valid  (win_valid),
        .sum_stall  (win_stall),
        .sum        (win_sum),
        .res_valid  (sc_valid),
        .res_stall  (sc_stall),
        .temp_rem   (sc_rem),
        .temp_base  (sc_temp_base),
        .avg        (sc_avg)
    );

    assign cfg_ready = 1'b1;

    always_comb
    begin
        alarm_next = alarm_reg;
        warn_next  = warn_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ALARM: alarm_next = cfg_data;
                CFG_WARN:  warn_next  = cfg_data;
                default:   ;
            endcase
        end
    end

    assign out_adv  = !out_valid_reg || !out_stall;
    assign sc_stall = !out_adv;

    always_comb
    begin
        temp_calc = (sc_rem >= REM_W'(TDIV)) ? sc_temp_base + TEMP_W'(1) : sc_temp_base;
        priority if (temp_calc > alarm_reg)
        begin
            level_calc = LEVEL_ALARM;
        end
        else if (temp_calc > warn_reg)
        begin
            level_calc = LEVEL_WARN;
        end
        else
        begin
            level_calc = LEVEL_NORMAL;
        end
        out_valid_next = out_adv ? sc_valid : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
        begin
            temperature_reg <= temp_calc;
            average_raw_reg <= sc_avg;
            level_reg       <= level_calc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg     <= ALARM_RESET;
            warn_reg      <= WARN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            alarm_reg     <= alarm_next;
            warn_reg      <= warn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign temperature = temperature_reg;
    assign average_raw = average_raw_reg;
    assign level       = level_reg;

`ifndef ASSERT_OFF
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temperature >= TEMP_MIN) && (temperature <= TEMP_MAX))
        else $error("Temperature result outside the reachable range.");

    a_stall_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("Input stalled although the output is draining.");

    a_alarm_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && $past(!out_valid || !out_stall) && (level == LEVEL_ALARM)
        |-> temperature > $past(alarm_reg))
        else $error("Alarm level reported at or below the alarm threshold.");
`endif

endmodule

>>> rtl/taa_window.sv
// Sample window of the temperature averaging block: ring memory and running sum.
// Depends on taa_pkg.
module taa_window
    import taa_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ADC_W-1:0]                 adc_sample,
    output logic                             sum_valid,
    input  logic                             sum_stall,
    output logic [sum_width(WINDOW)-1:0]     sum
);

    localparam int SUM_W = sum_width(WINDOW);
    localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [ADC_W-1:0]  mem [WINDOW];
    logic [WINDOW-1:0] filled_reg;
    logic [PTR_W-1:0]  pos_reg;
    logic [PTR_W-1:0]  pos_next;
    logic [PTR_W-1:0]  rd_addr;
    logic [ADC_W-1:0]  mem_q_reg;
    logic [ADC_W-1:0]  byp_data_reg;
    logic              byp_reg;
    logic              byp_next;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic [ADC_W-1:0]  oldest;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic              valid_reg;
    logic              valid_next;
    logic              accept;

    assign in_stall  = valid_reg && sum_stall;
    assign accept    = in_valid && !in_stall;
    assign sum_valid = valid_reg;
    assign sum       = sum_reg;

    always_comb
    begin
        pos_next      = (pos_reg == PTR_W'(WINDOW - 1)) ? '0 : pos_reg + PTR_W'(1);
        rd_addr       = accept ? pos_next : pos_reg;
        byp_next      = accept && (pos_next == pos_reg);
        rd_valid_next = byp_next || filled_reg[rd_addr];
        if (!rd_valid_reg)
        begin
            oldest = '0;
        end
        else if (byp_reg)
        begin
            oldest = byp_data_reg;
        end
        else
        begin
            oldest = mem_q_reg;
        end
        sum_next   = sum_reg + SUM_W'(adc_sample) - SUM_W'(oldest);
        valid_next = sum_stall ? (valid_reg || accept) : accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[pos_reg] <= adc_sample;
        end
        mem_q_reg    <= mem[rd_addr];
        byp_data_reg <= adc_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg   <= '0;
            pos_reg      <= '0;
            byp_reg      <= 1'b0;
            rd_valid_reg <= 1'b0;
            sum_reg      <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            byp_reg      <= byp_next;
            rd_valid_reg <= rd_valid_next;
            valid_reg    <= valid_next;
            if (accept)
            begin
                filled_reg[pos_reg] <= 1'b1;
                pos_reg             <= pos_next;
                sum_reg             <= sum_next;
            end
        end
    end

endmodule

>>> rtl/taa_scale.sv
// Scaling pipeline of the temperature averaging block: reciprocal multiplies
// that turn the window sum into the raw average and a temperature estimate.
// Depends on taa_pkg.
module taa_scale
    import taa_pkg::*;
#(
    parameter int WINDOW = DEFAULT_WINDOW
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             sum_valid,
    output logic                             sum_stall,
    input  logic [sum_width(WINDOW)-1:0]     sum,
    output logic                             res_valid,
    input  logic                             res_stall,
    output logic [rem_width(WINDOW)-1:0]     temp_rem,
    output logic signed [TEMP_W-1:0]         temp_base,
    output logic [AVG_W-1:0]                 avg
);

    localparam int SUM_W       = sum_width(WINDOW);
    localparam int NUM_W       = num_width(WINDOW);
    localparam int TDIV        = tdiv(WINDOW);
    localparam int REM_W       = rem_width(WINDOW);
    localparam int AVG_RECIP   = (2 ** SUM_W) / WINDOW;
    localparam int AVG_RECIP_W = $clog2(AVG_RECIP + 1);
    localparam int AP_W        = SUM_W + AVG_RECIP_W;
    localparam int T_RECIP     = (2 ** NUM_W) / TDIV;
    localparam int T_RECIP_W   = $clog2(T_RECIP + 1);
    localparam int TP_W        = NUM_W + T_RECIP_W;
    localparam int TQ_W        = $clog2(num_max(WINDOW) / TDIV + 1);
    localparam int TB_W        = TQ_W + 1;

    logic                     a_valid_reg;
    logic [NUM_W-1:0]         a_num_reg;
    logic [SUM_W-1:0]         a_sum_reg;
    logic [AVG_W-1:0]         a_avgq_reg;
    logic                     b_valid_reg;
    logic [NUM_W-1:0]         b_num_reg;
    logic [TQ_W-1:0]          b_tq_reg;
    logic [AVG_W-1:0]         b_avgq_reg;
    logic [SUM_W-1:0]         b_avgr_reg;
    logic                     c_valid_reg;
    logic [REM_W-1:0]         c_rem_reg;
    logic signed [TEMP_W-1:0] c_temp_reg;
    logic [AVG_W-1:0]         c_avg_reg;

    logic                     a_adv;
    logic                     b_adv;
    logic                     c_adv;
    logic [NUM_W-1:0]         num_next;
    logic [AP_W-1:0]          avg_prod;
    logic [AVG_W-1:0]         avgq_next;
    logic [TP_W-1:0]          t_prod;
    logic [TQ_W-1:0]          tq_next;
    logic [SUM_W-1:0]         avgr_next;
    logic [REM_W-1:0]         rem_next;
    logic signed [TB_W-1:0]   tb;
    logic signed [TEMP_W-1:0] temp_next;
    logic [AVG_W-1:0]         avg_next;

    assign c_adv     = !c_valid_reg || !res_stall;
    assign b_adv     = !b_valid_reg || c_adv;
    assign a_adv     = !a_valid_reg || b_adv;
    assign sum_stall = !a_adv;

    assign res_valid = c_valid_reg;
    assign temp_rem  = c_rem_reg;
    assign temp_base = c_temp_reg;
    assign avg       = c_avg_reg;

    always_comb
    begin
        num_next  = NUM_W'(sum) * NUM_W'(NUM_GAIN) + NUM_W'(NUM_BIAS * WINDOW);
        avg_prod  = AP_W'(sum) * AP_W'(AVG_RECIP);
        avgq_next = AVG_W'(avg_prod >> SUM_W);

        t_prod    = TP_W'(a_num_reg) * TP_W'(T_RECIP);
        tq_next   = TQ_W'(t_prod >> NUM_W);
        avgr_next = a_sum_reg - SUM_W'(SUM_W'(a_avgq_reg) * SUM_W'(WINDOW));

        rem_next  = REM_W'(b_num_reg - NUM_W'(NUM_W'(b_tq_reg) * NUM_W'(TDIV)));
        tb        = $signed({1'b0, b_tq_reg}) - TB_W'(TEMP_OFFSET);
        temp_next = TEMP_W'(tb);
        avg_next  = (b_avgr_reg >= SUM_W'(WINDOW)) ? b_avgq_reg + AVG_W'(1) : b_avgq_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            a_num_reg  <= num_next;
            a_sum_reg  <= sum;
            a_avgq_reg <= avgq_next;
        end
        if (b_adv)
        begin
            b_num_reg  <= a_num_reg;
            b_tq_reg   <= tq_next;
            b_avgq_reg <= a_avgq_reg;
            b_avgr_reg <= avgr_next;
        end
        if (c_adv)
        begin
            c_rem_reg  <= rem_next;
            c_temp_reg <= temp_next;
            c_avg_reg  <= avg_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= sum_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_adv)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for temperature_average_alarm: drives converter samples and
// threshold register writes, and checks every transaction against a behavioral predictor or fixed expected values.
// Depends on taa_pkg and the temperature_average_alarm RTL.
module testbench;
    import taa_pkg::*;

    localparam int WIN             = DEFAULT_WINDOW;
    localparam int PIPE_LATENCY    = 4;
    localparam int SETTLE_CYCLES   = 2 * PIPE_LATENCY;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int TEMP_SCALE      = 625;
    localparam int TEMP_BIAS       = 51200;
    localparam int TEMP_DIV        = 156;
    localparam int THR_MAX         = 4095;
    localparam int THR_MIN         = -512;
    localparam int RANDOM_PHASES   = 6;
    localparam int PHASE_ITEMS     = 100;
    localparam int STEADY_FIRST    = 200;
    localparam int STEADY_LAST     = 320;
    localparam int HOLD_AT         = 450;
    localparam int HOLD_CYCLES     = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        logic [AVG_W-1:0]         avg;
        level_t                   lvl;
    } reading_t;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [ADC_W-1:0]      sample;
        bit                    fixed;
        reading_t              want;
    } step_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [ADC_W-1:0]         adc_sample;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [TEMP_W-1:0] temperature;
    logic [AVG_W-1:0]         average_raw;
    logic [LEVEL_W-1:0]       level;

    logic [ADC_W-1:0]         ring [WIN];
    int                       ring_pos;
    int                       ring_sum;
    logic signed [TEMP_W-1:0] alarm_thr;
    logic signed [TEMP_W-1:0] warn_thr;
    reading_t                 pending_q [$];
    reading_t                 no_reading;
    step_t                    plan [$];
    int                       fail_count;
    int                       sample_count;
    int                       cycle_count;
    bit                       steady;

    temperature_average_alarm #(
        .WINDOW(WIN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .adc_sample(adc_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .temperature(temperature),
        .average_raw(average_raw),
        .level(level)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Updates the window, the running sum and the ring pointer, then derives the reading.
    function automatic reading_t predict_reading(input logic [ADC_W-1:0] s);
        reading_t r;
        int numer;
        int quot;
        ring_sum = ring_sum - int'(ring[ring_pos]) + int'(s);
        ring[ring_pos] = s;
        ring_pos = (ring_pos == WIN - 1) ? 0 : ring_pos + 1;
        numer = TEMP_SCALE * ring_sum - TEMP_BIAS * WIN;
        quot = numer / (TEMP_DIV * WIN);
        if (numer % (TEMP_DIV * WIN) != 0 && numer < 0)
            quot = quot - 1;
        r.temp = quot[TEMP_W-1:0];
        r.avg = AVG_W'(ring_sum / WIN);
        if (quot > alarm_thr)
            r.lvl = LEVEL_ALARM;
        else if (quot > warn_thr)
            r.lvl = LEVEL_WARN;
        else
            r.lvl = LEVEL_NORMAL;
        return r;
    endfunction

    function automatic void add_sample(input logic [ADC_W-1:0] s);
        step_t st;
        st.is_write = 1'b0;
        st.sample = s;
        st.fixed = 1'b0;
        plan.push_back(st);
    endfunction

    function automatic void add_check(input logic [ADC_W-1:0] s, input int temp,
                                      input int avg, input level_t lvl);
        step_t st;
        st.is_write = 1'b0;
        st.sample = s;
        st.fixed = 1'b1;
        st.want.temp = TEMP_W'(temp);
        st.want.avg = AVG_W'(avg);
        st.want.lvl = lvl;
        plan.push_back(st);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        step_t st;
        st.is_write = 1'b1;
        st.idx = idx;
        st.data = data;
        plan.push_back(st);
    endfunction

    function automatic logic [ADC_W-1:0] pick_sample(input int center, input int spread);
        int v;
        case ($urandom_range(19))
            0:       v = 0;
            1:       v = ADC_MAX;
            2, 3:    v = int'($urandom_range(ADC_MAX));
            default: v = center + int'($urandom_range(2 * spread)) - spread;
        endcase
        if (v < 0)
            v = 0;
        if (v > ADC_MAX)
            v = ADC_MAX;
        return v[ADC_W-1:0];
    endfunction

    // Half of the thresholds land near the temperature of the phase's sample center.
    function automatic logic [CFG_DATA_W-1:0] pick_threshold(input int center);
        int t;
        case ($urandom_range(9))
            0:       t = THR_MAX;
            1:       t = THR_MIN;
            2:       t = int'($urandom);
            3, 4:    t = int'($urandom_range(4099)) - 329;
            default: t = (TEMP_SCALE * center - TEMP_BIAS) / TEMP_DIV
                         + int'($urandom_range(400)) - 200;
        endcase
        return t[CFG_DATA_W-1:0];
    endfunction

    task automatic send_sample(input logic [ADC_W-1:0] s, input bit fixed,
                               input reading_t want);
        reading_t model;
        steady = (sample_count >= STEADY_FIRST && sample_count < STEADY_LAST);
        while (!steady && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        adc_sample <= s;
        do
            @(posedge clk);
        while (in_stall);
        model = predict_reading(s);
        if (fixed)
            pending_q.push_back(want);
        else
            pending_q.push_back(model);
        sample_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_ALARM)
            alarm_thr = val;
        else if (idx == CFG_WARN)
            warn_thr = val;
    endtask

    always @(posedge clk)
    begin : check_result
        reading_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected transaction: temperature %0d, average_raw %0d, level %0d",
                       temperature, average_raw, level);
                fail_count++;
            end
            else
            begin
                exp_r = pending_q.pop_front();
                if (temperature !== exp_r.temp)
                begin
                    $error("temperature: expected %0d, actual %0d", exp_r.temp, temperature);
                    fail_count++;
                end
                if (average_raw !== exp_r.avg)
                begin
                    $error("average_raw: expected %0d, actual %0d", exp_r.avg, average_raw);
                    fail_count++;
                end
                if (level !== exp_r.lvl)
                begin
                    $error("level: expected %0d, actual %0d", exp_r.lvl, level);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // The output side stalls at random outside the steady phase, and once holds off long enough to back up the input.
    initial
    begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sample_count >= HOLD_AT)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (steady)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 25);
        end
    end

    initial
    begin : stimulus
        int i;
        int p;
        int k;
        int center;
        int spread;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ALARM;
        cfg_data = '0;
        in_valid = 1'b0;
        adc_sample = '0;
        fail_count = 0;
        sample_count = 0;
        cycle_count = 0;
        steady = 1'b0;
        for (i = 0; i < WIN; i++)
            ring[i] = '0;
        ring_pos = 0;
        ring_sum = 0;
        alarm_thr = ALARM_RESET;
        warn_thr = WARN_RESET;
        no_reading.temp = '0;
        no_reading.avg = '0;
        no_reading.lvl = LEVEL_NORMAL;

        add_check(10'd0, -329, 0, LEVEL_NORMAL);
        for (i = 0; i < WIN - 1; i++)
            add_sample(10'd1023);
        add_check(10'd1023, 3770, 1023, LEVEL_ALARM);
        add_write(CFG_ALARM, 13'd3770);
        add_write(CFG_WARN, 13'd3769);
        add_check(10'd1023, 3770, 1023, LEVEL_WARN);
        add_write(CFG_WARN, 13'd3770);
        add_check(10'd1023, 3770, 1023, LEVEL_NORMAL);
        add_write(CFG_ALARM, 13'd1000);
        add_write(CFG_WARN, 13'd4095);
        add_write(CFG_UNMAPPED_LO, 13'h0FFF);
        add_write(CFG_UNMAPPED_HI, 13'h1E00);
        add_check(10'd1023, 3770, 1023, LEVEL_ALARM);
        add_sample(10'd0);
        add_sample(10'd512);
        add_sample(10'd0);
        add_sample(10'd700);
        add_sample(10'd300);
        add_sample(10'd1);
        add_sample(10'd1022);
        add_write(CFG_ALARM, 13'h1E00);
        add_write(CFG_WARN, 13'h1000);
        add_sample(10'd0);
        add_sample(10'd0);
        add_sample(10'd0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].is_write)
            begin
                if (i == 0 || !plan[i-1].is_write)
                    drain();
                write_reg(plan[i].idx, plan[i].data);
                if (i + 1 >= plan.size() || !plan[i+1].is_write)
                    cfg_valid <= 1'b0;
            end
            else
                send_sample(plan[i].sample, plan[i].fixed, plan[i].want);
        end

        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            center = int'($urandom_range(ADC_MAX));
            spread = int'($urandom_range(300, 1));
            if ($urandom_range(1))
            begin
                write_reg(CFG_ALARM, pick_threshold(center));
                write_reg(CFG_WARN, pick_threshold(center));
            end
            else
            begin
                write_reg(CFG_WARN, pick_threshold(center));
                write_reg(CFG_ALARM, pick_threshold(center));
            end
            if ($urandom_range(3) == 0)
                write_reg($urandom_range(1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI,
                          CFG_DATA_W'($urandom));
            cfg_valid <= 1'b0;
            for (k = 0; k < PHASE_ITEMS; k++)
                send_sample(pick_sample(center, spread), 1'b0, no_reading);
        end

        drain();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> files.f
rtl/taa_pkg.sv
rtl/taa_window.sv
rtl/taa_scale.sv
rtl/temperature_average_alarm.sv
sim/testbench.sv
